@@ sv/tir_pkg.sv @@
// ============================================================================
// tir_pkg: shared types and constants for the TFTP image block reassembler
// Item classes, result status codes, register map and reset values.
// ============================================================================
package tir_pkg;

    // Register map (index = paddr[3:2])
    localparam int          REG_ADDR_W      = 4;
    localparam logic [1:0]  REG_CAPACITY    = 2'd0;
    localparam logic [1:0]  REG_BLOCK_SIZE  = 2'd1;
    localparam logic [1:0]  REG_HEADER_LEN  = 2'd2;

    localparam logic [15:0] BLOCK_SIZE_RST  = 16'd1450;
    localparam logic [11:0] HEADER_LEN_RST  = 12'd595;
    localparam logic [31:0] CAPACITY_RST    = 32'd0;

    localparam int          RETRY_LIMIT_DEF = 10;
    localparam int          QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0]  OPCODE_DATA     = 8'h03;
    localparam logic [7:0]  MARK_HI         = 8'hFF;
    localparam logic [7:0]  MARK_LO         = 8'hD8;

    typedef enum logic [2:0] {
        ST_CONT   = 3'd0,
        ST_DONE   = 3'd1,
        ST_OOM    = 3'd2,
        ST_RETRY  = 3'd3,
        ST_RXFAIL = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        K_START = 2'd0,
        K_FAIL  = 2'd1,
        K_RETRY = 2'd2,
        K_DATA  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [31:0] capacity;
        logic [15:0] block_size;
        logic [11:0] header_length;
    } t_cfg;

    // Classified item, front to back
    typedef struct packed {
        t_kind       kind;
        logic [15:0] blk;
        logic [15:0] plen;
        logic        strip;   // payload starts with the JPEG SOI marker
        logic        short_blk;
        logic [31:0] base;    // (blk-1)*block_size mod 2^32
    } t_cmd;

    typedef struct packed {
        t_status     status;
        logic        send_ack;
        logic [15:0] ack_block;
        logic        copy_enable;
        logic [31:0] dest_offset;
        logic [1:0]  source_skip;
        logic [15:0] copy_length;
        logic        first_block;
        logic [31:0] total_size;
    } t_result;

endpackage

@@ sv/tir_fifo.sv @@
// ============================================================================
// tir_fifo: small register queue
// Count-based FIFO, one push (while not full) and one pop (while not empty) per cycle.
// ============================================================================
module tir_fifo
    import tir_pkg::*;
#(
    parameter int  DEPTH  = QUEUE_DEPTH_DEF,
    parameter type t_data = logic
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_data i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_data o_data,
    output logic  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_data          r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           w_do_push, w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ sv/tir_cfg.sv @@
// ============================================================================
// tir_cfg: configuration registers
// APB-style register file: capacity, block size, header length.
// ============================================================================
module tir_cfg
    import tir_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);
    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capacity      <= CAPACITY_RST;
            r_cfg.block_size    <= BLOCK_SIZE_RST;
            r_cfg.header_length <= HEADER_LEN_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_CAPACITY:   r_cfg.capacity      <= pwdata;
                REG_BLOCK_SIZE: r_cfg.block_size    <= pwdata[15:0];
                REG_HEADER_LEN: r_cfg.header_length <= pwdata[11:0];
                default:        r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_CAPACITY:   prdata = r_cfg.capacity;
            REG_BLOCK_SIZE: prdata = {16'd0, r_cfg.block_size};
            REG_HEADER_LEN: prdata = {20'd0, r_cfg.header_length};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

@@ sv/tir_front.sv @@
// ============================================================================
// tir_front: item classifier
// Sorts items into start/fail/retry/data and precomputes the block base.
// ============================================================================
module tir_front
    import tir_pkg::*;
(
    input  logic        i_operation,
    input  logic        i_receive_failed,
    input  logic [7:0]  i_opcode_byte,
    input  logic [15:0] i_block_number,
    input  logic [15:0] i_payload_length,
    input  logic [7:0]  i_payload_byte0,
    input  logic [7:0]  i_payload_byte1,
    input  t_cfg        i_cfg,
    output t_cmd        o_cmd
);
    logic signed [16:0] w_blk_m1;
    logic signed [16:0] w_bs;
    logic signed [33:0] w_prod;

    // blk-1 as signed so block zero wraps correctly mod 2^32
    assign w_blk_m1 = $signed({1'b0, i_block_number}) - 17'sd1;
    assign w_bs     = $signed({1'b0, i_cfg.block_size});
    assign w_prod   = w_blk_m1 * w_bs;

    always_comb begin
        if (!i_operation) begin
            o_cmd.kind = K_START;
        end else if (i_receive_failed) begin
            o_cmd.kind = K_FAIL;
        end else if (i_opcode_byte != OPCODE_DATA) begin
            o_cmd.kind = K_RETRY;
        end else begin
            o_cmd.kind = K_DATA;
        end
        o_cmd.blk       = i_block_number;
        o_cmd.plen      = i_payload_length;
        o_cmd.strip     = (i_payload_length >= 16'd2) && (i_payload_byte0 == MARK_HI)
                          && (i_payload_byte1 == MARK_LO);
        o_cmd.short_blk = (i_payload_length < i_cfg.block_size);
        o_cmd.base      = w_prod[31:0];
    end

endmodule

@@ sv/tir_back.sv @@
// ============================================================================
// tir_back: transfer state and result builder
// Holds the byte count, strip offset, retry count and finished mark.
// ============================================================================
module tir_back
    import tir_pkg::*;
#(
    parameter int RETRY_LIMIT = RETRY_LIMIT_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_cmd    i_cmd,
    input  logic    i_cmd_valid,
    output logic    o_cmd_pop,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res
);
    logic [31:0] r_bytes, n_bytes;
    logic [31:0] r_strip, n_strip;
    logic [3:0]  r_retry, n_retry;
    logic        r_finished, n_finished;

    logic        w_fire;
    logic        w_has_res;
    logic [33:0] w_need;
    logic        w_ovf;
    logic [3:0]  w_retry_inc;

    assign w_fire      = i_cmd_valid && !i_res_full;
    assign o_cmd_pop   = w_fire;
    assign o_res_push  = w_fire && w_has_res;
    assign w_retry_inc = r_retry + 4'd1;
    assign w_need      = 34'(i_cmd.plen) + 34'(r_bytes) + 34'(i_cfg.header_length);
    assign w_ovf       = (w_need > 34'(i_cfg.capacity));

    always_comb begin
        n_bytes    = r_bytes;
        n_strip    = r_strip;
        n_retry    = r_retry;
        n_finished = r_finished;
        w_has_res  = 1'b0;
        o_res      = '0;
        o_res.status = ST_CONT;

        if (i_cmd.kind == K_START) begin
            n_bytes    = '0;
            n_strip    = '0;
            n_retry    = '0;
            n_finished = 1'b0;
        end else if (!r_finished) begin
            w_has_res = 1'b1;
            case (i_cmd.kind)
                K_FAIL: begin
                    o_res.status = ST_RXFAIL;
                    n_finished   = 1'b1;
                end
                K_RETRY: begin
                    n_retry = w_retry_inc;
                    if (w_retry_inc >= 4'(RETRY_LIMIT)) begin
                        o_res.status = ST_RETRY;
                        n_finished   = 1'b1;
                    end
                end
                K_DATA: begin
                    o_res.send_ack    = 1'b1;
                    o_res.ack_block   = i_cmd.blk;
                    o_res.first_block = (i_cmd.blk == 16'd1);
                    if (w_ovf) begin
                        o_res.status = ST_OOM;
                        n_finished   = 1'b1;
                    end else begin
                        o_res.copy_enable = 1'b1;
                        o_res.dest_offset = i_cmd.base - r_strip;
                        if (i_cmd.strip) begin
                            o_res.source_skip = 2'd2;
                            o_res.copy_length = i_cmd.plen - 16'd2;
                            n_strip           = r_strip + 32'd2;
                        end else begin
                            o_res.copy_length = i_cmd.plen;
                        end
                        n_bytes = r_bytes + 32'(o_res.copy_length);
                        if (i_cmd.short_blk) begin
                            o_res.status = ST_DONE;
                            n_finished   = 1'b1;
                        end
                    end
                end
                default: begin
                    w_has_res = 1'b0;
                end
            endcase
        end
        o_res.total_size = 32'(i_cfg.header_length) + n_bytes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes    <= '0;
            r_strip    <= '0;
            r_retry    <= '0;
            r_finished <= 1'b1;
        end else if (w_fire) begin
            r_bytes    <= n_bytes;
            r_strip    <= n_strip;
            r_retry    <= n_retry;
            r_finished <= n_finished;
        end
    end

    // A copy is only ever issued for an acknowledged DATA packet
    a_copy_has_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push && o_res.copy_enable |-> o_res.send_ack)
        else $error("copy without ack");

    // Any terminal status leaves the transfer finished
    a_term_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push && (o_res.status != ST_CONT) |=> r_finished)
        else $error("terminal status did not finish transfer");

    // Out of memory never comes with a copy
    a_oom_no_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push && (o_res.status == ST_OOM) |-> !o_res.copy_enable)
        else $error("copy issued on overflow");

    // A start clears the transfer state
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && (i_cmd.kind == K_START) |=> !r_finished && (r_bytes == '0)
        && (r_strip == '0) && (r_retry == '0))
        else $error("start did not clear state");

    // No result while finished, except none from a start
    a_no_res_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> !o_res_push)
        else $error("result while transfer finished");

endmodule

@@ sv/tftp_image_block_reassembler.sv @@
// ============================================================================
// tftp_image_block_reassembler: TFTP DATA receive and image reassembly
// Turns packet header summaries into ACK requests and copy commands.
// ============================================================================
// Throughput is one item per clock while full is low: the classifier and
// the block-base multiply (one 17x17 product) sit in front of a small
// command queue, and the back end updates the transfer counters as it pops
// each item, so a new item can be pushed every cycle while results drain.
// An item that yields a result is written to the command queue, then the
// back end pushes its result into the result queue, from which it shows on
// the result ports. Push stalls (full) only when the command queue is full,
// which happens when the result queue is full and pop is held low.
// Start items and packets seen after a transfer finished produce no result.
// Configuration registers sit at byte offsets 0 (buffer_capacity),
// 4 (block_size) and 8 (header_length); write them only while no item is in
// flight.
// ============================================================================
module tftp_image_block_reassembler
    import tir_pkg::*;
#(
    parameter int RETRY_LIMIT = RETRY_LIMIT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // config port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,

    // item input
    input  logic                  push,
    output logic                  full,
    input  logic                  i_operation,
    input  logic                  i_receive_failed,
    input  logic [7:0]            i_opcode_byte,
    input  logic [15:0]           i_block_number,
    input  logic [15:0]           i_payload_length,
    input  logic [7:0]            i_payload_byte0,
    input  logic [7:0]            i_payload_byte1,

    // result output
    output logic                  empty,
    input  logic                  pop,
    output logic [2:0]            o_status,
    output logic                  o_send_ack,
    output logic [15:0]           o_ack_block,
    output logic                  o_copy_enable,
    output logic [31:0]           o_dest_offset,
    output logic [1:0]            o_source_skip,
    output logic [15:0]           o_copy_length,
    output logic                  o_first_block,
    output logic [31:0]           o_total_size
);
    t_cfg    w_cfg;
    t_cmd    w_cmd_in, w_cmd_out;
    logic    w_cmd_empty, w_cmd_pop;
    t_result w_res_in, w_res_out;
    logic    w_res_push, w_res_full;

    tir_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Front: classify and precompute the block base
    tir_front u_front (
        .i_operation      (i_operation),
        .i_receive_failed (i_receive_failed),
        .i_opcode_byte    (i_opcode_byte),
        .i_block_number   (i_block_number),
        .i_payload_length (i_payload_length),
        .i_payload_byte0  (i_payload_byte0),
        .i_payload_byte1  (i_payload_byte1),
        .i_cfg            (w_cfg),
        .o_cmd            (w_cmd_in)
    );

    // Command queue decouples front from back
    tir_fifo #(
        .DEPTH  (QUEUE_DEPTH),
        .t_data (t_cmd)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_cmd_in),
        .o_full  (full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    // Back: transfer state, one command per cycle unless the result queue is full
    tir_back #(
        .RETRY_LIMIT (RETRY_LIMIT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd_out),
        .i_cmd_valid (!w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in)
    );

    // Result queue: back keeps working while the consumer stalls
    tir_fifo #(
        .DEPTH  (QUEUE_DEPTH),
        .t_data (t_result)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty)
    );

    assign o_status      = w_res_out.status;
    assign o_send_ack    = w_res_out.send_ack;
    assign o_ack_block   = w_res_out.ack_block;
    assign o_copy_enable = w_res_out.copy_enable;
    assign o_dest_offset = w_res_out.dest_offset;
    assign o_source_skip = w_res_out.source_skip;
    assign o_copy_length = w_res_out.copy_length;
    assign o_first_block = w_res_out.first_block;
    assign o_total_size  = w_res_out.total_size;

endmodule
